### sv/toq_pkg.sv
// Package for the tilt orientation quadrant block: transfer payload types and codes.
// It has no dependencies and is imported by tilt_orientation_quadrant_core.
`timescale 1ns / 1ps

package toq_pkg;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 15;

  localparam logic [CfgIndexWidth-1:0] CFG_ALPHA_SHIFT     = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_MIN_TILT_COUNTS = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_ROTATION_NEGATE = 2'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_OFFSET_QUARTERS = 2'd3;

  localparam logic [2:0]  ALPHA_SHIFT_RESET     = 3'd2;
  localparam logic [14:0] MIN_TILT_COUNTS_RESET = 15'd3277;
  localparam logic        ROTATION_NEGATE_RESET = 1'b1;
  localparam logic [1:0]  OFFSET_QUARTERS_RESET = 2'd0;

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_FAIL   = 2'd1;
  localparam logic [1:0] FUNC_LOCK   = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic               lock_value;
  } toq_in_t;

  typedef struct packed {
    logic [8:0] angle_deg;
    logic       is_locked;
    logic       tilt_ok;
  } toq_out_t;

endpackage

### sv/tilt_orientation_quadrant_core.sv
// Top level of the tilt orientation quadrant block: averaging, tilt threshold and
// quarter-turn orientation with lock. Depends on toq_pkg for payload types and codes.
//
//   channel   direction  handshake                 payload
//   in        receive    in_valid / in_stall       toq_in_t   (func, accel, lock)
//   out       send       out_valid / out_stall     toq_out_t  (angle, lock, tilt)
//   cfg       receive    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item per cycle while the output is not stalled.
// The item in the input register is processed and its state update made as it moves
// into the result register, which frees the input register for the next item.
// A stall on the output backs up into in_stall only when both registers are full.
// Reset is synchronous and restores the configuration, valid flags and state; data registers are not reset.
`timescale 1ns / 1ps

module tilt_orientation_quadrant_core
  import toq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  toq_in_t                  in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output toq_out_t                 out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  function automatic logic [1:0] quarter_ties_up(logic signed [18:0] x, logic signed [18:0] y,
                                                 logic signed [18:0] nx);
    logic [1:0] q;
    if (y < x && y >= nx) begin
      q = 2'd0;
    end else if (y >= x && y > nx) begin
      q = 2'd1;
    end else if (y > x && y <= nx) begin
      q = 2'd2;
    end else begin
      q = 2'd3;
    end
    return q;
  endfunction

  function automatic logic [1:0] quarter_ties_down(logic signed [18:0] x,
                                                   logic signed [18:0] y,
                                                   logic signed [18:0] nx);
    logic [1:0] q;
    if (y <= x && y > nx) begin
      q = 2'd0;
    end else if (y > x && y >= nx) begin
      q = 2'd1;
    end else if (y < nx && y >= x) begin
      q = 2'd2;
    end else begin
      q = 2'd3;
    end
    return q;
  endfunction

  function automatic logic [8:0] quarter_to_deg(logic [1:0] q);
    logic [8:0] d;
    case (q)
      2'd0:    d = 9'd0;
      2'd1:    d = 9'd90;
      2'd2:    d = 9'd180;
      default: d = 9'd270;
    endcase
    return d;
  endfunction

  logic [2:0]  alpha_shift;
  logic [14:0] min_tilt_counts;
  logic        rotation_negate;
  logic [1:0]  offset_quarters;
  logic [29:0] min_sq;
  logic [35:0] thr_sq;

  logic        s1_valid;
  toq_in_t     s1;
  logic        advance;

  logic signed [17:0] avg_x;
  logic signed [17:0] avg_y;
  logic               avg_valid;
  logic [1:0]         live_quarter;
  logic [1:0]         held_quarter;
  logic               lock_flag;

  logic signed [17:0] avg_x_next;
  logic signed [17:0] avg_y_next;
  logic               avg_valid_next;
  logic [1:0]         live_quarter_next;
  logic [1:0]         held_quarter_next;
  logic               lock_flag_next;
  toq_out_t           result;

  logic signed [17:0] tx;
  logic signed [17:0] ty;
  logic signed [18:0] diff_x;
  logic signed [18:0] diff_y;
  logic signed [18:0] step_x;
  logic signed [18:0] step_y;
  logic signed [18:0] sum_x;
  logic signed [18:0] sum_y;
  logic signed [35:0] sq_x;
  logic signed [35:0] sq_y;
  logic [35:0]        mag_sq;
  logic signed [18:0] wx;
  logic signed [18:0] wy;
  logic signed [18:0] nwx;
  logic [1:0]         gravity_q;
  logic               tilt_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_shift     <= ALPHA_SHIFT_RESET;
      min_tilt_counts <= MIN_TILT_COUNTS_RESET;
      rotation_negate <= ROTATION_NEGATE_RESET;
      offset_quarters <= OFFSET_QUARTERS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ALPHA_SHIFT:     alpha_shift     <= cfg_data[2:0];
        CFG_MIN_TILT_COUNTS: min_tilt_counts <= cfg_data[14:0];
        CFG_ROTATION_NEGATE: rotation_negate <= cfg_data[0];
        CFG_OFFSET_QUARTERS: offset_quarters <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // The squared threshold is registered; configuration settles while the block is idle (not enforced by the block).
  assign min_sq = {15'd0, min_tilt_counts} * {15'd0, min_tilt_counts};

  always_ff @(posedge clk) begin
    thr_sq <= {2'b00, min_sq, 4'b0000};
  end

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (s1_valid && !advance) || (in_valid && !in_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1 <= in_data;
    end
  end

  always_comb begin
    tx     = {s1.accel_x, 2'b00};
    ty     = {s1.accel_y, 2'b00};
    diff_x = {tx[17], tx} - {avg_x[17], avg_x};
    diff_y = {ty[17], ty} - {avg_y[17], avg_y};
    step_x = diff_x >>> alpha_shift;
    step_y = diff_y >>> alpha_shift;
    sum_x  = {avg_x[17], avg_x} + step_x;
    sum_y  = {avg_y[17], avg_y} + step_y;

    avg_x_next        = avg_x;
    avg_y_next        = avg_y;
    avg_valid_next    = avg_valid;
    live_quarter_next = live_quarter;
    held_quarter_next = held_quarter;
    lock_flag_next    = lock_flag;

    case (s1.func)
      FUNC_SAMPLE: begin
        avg_valid_next = 1'b1;
        if (avg_valid) begin
          avg_x_next = sum_x[17:0];
          avg_y_next = sum_y[17:0];
        end else begin
          avg_x_next = tx;
          avg_y_next = ty;
        end
      end
      FUNC_FAIL: begin
        avg_valid_next = 1'b0;
      end
      FUNC_LOCK: begin
        if (s1.lock_value && !lock_flag) begin
          held_quarter_next = live_quarter;
        end
        lock_flag_next = s1.lock_value;
      end
      default: ;
    endcase

    sq_x   = avg_x_next * avg_x_next;
    sq_y   = avg_y_next * avg_y_next;
    mag_sq = 36'(sq_x) + 36'(sq_y);
    wx     = {avg_x_next[17], avg_x_next};
    wy     = {avg_y_next[17], avg_y_next};
    nwx    = -wx;

    if (wx == '0 && wy == '0) begin
      gravity_q = 2'd0;
    end else if (rotation_negate) begin
      gravity_q = 2'(3'd4 - {1'b0, quarter_ties_down(wx, wy, nwx)});
    end else begin
      gravity_q = quarter_ties_up(wx, wy, nwx);
    end

    tilt_ok = (s1.func == FUNC_SAMPLE) && (mag_sq >= thr_sq);
    if (tilt_ok) begin
      live_quarter_next = gravity_q + offset_quarters;
    end

    result.angle_deg = quarter_to_deg(lock_flag_next ? held_quarter_next : live_quarter_next);
    result.is_locked = lock_flag_next;
    result.tilt_ok   = tilt_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_x        <= '0;
      avg_y        <= '0;
      avg_valid    <= 1'b0;
      live_quarter <= 2'd0;
      held_quarter <= 2'd0;
      lock_flag    <= 1'b0;
    end else if (advance && s1_valid) begin
      avg_x        <= avg_x_next;
      avg_y        <= avg_y_next;
      avg_valid    <= avg_valid_next;
      live_quarter <= live_quarter_next;
      held_quarter <= held_quarter_next;
      lock_flag    <= lock_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  // The held angle may only change on a lock transfer.
  assert property (@(posedge clk) disable iff (rst)
    lock_flag && !(advance && s1_valid && s1.func == FUNC_LOCK) |=> $stable(held_quarter))
    else $error("held quarter changed while locked");

  // The average is invalidated only by a read failure item or by reset.
  assert property (@(posedge clk) disable iff (rst)
    $fell(avg_valid) |-> $past(rst) || $past(advance && s1_valid && s1.func == FUNC_FAIL))
    else $error("average invalidated without a read failure");

  // An unlocked result shows the live quarter for as long as it waits.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_locked |-> out_data.angle_deg == quarter_to_deg(live_quarter))
    else $error("unlocked result does not match the live quarter");

  // A result reporting a lock always matches the lock state.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.is_locked == lock_flag)
    else $error("result lock flag does not match the lock state");
`endif

endmodule
